// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property sampled on the rising clock edge, ignored while in reset.
`define ASSERT_CLKD(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// An implication that must hold in the same cycle as its trigger.
`define ASSERT_IMPL(label, trig, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/uule_pkg.sv =====
package uule_pkg;

  localparam logic [7:0] CH_BIAS = 8'h20;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;

  // Bytes per encoded group, and the index of the last step of a group fetch.
  localparam int unsigned GROUP_BYTES   = 3;
  localparam logic [1:0]  FETCH_LAST    = 2'd3;

  typedef struct packed {
    logic blk_end;  // last byte of the block
    logic close;    // this byte completes a line
  } uule_tag_t;

  typedef enum logic [3:0] {
    ST_TAKE,
    ST_LEN,
    ST_FETCH,
    ST_C0,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_CR,
    ST_LF
  } uule_state_e;

  function automatic logic [7:0] bias6(input logic [5:0] v);
    bias6 = CH_BIAS + {2'b00, v};
  endfunction

endpackage

// ===== hdl/uule_if.sv =====
interface uule_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_end;

  modport source (output valid, output data_byte, output block_end, input ready);
  modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

interface uule_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        line_last;
  logic        block_done;
  logic [31:0] block_sum;

  modport source (output valid, output out_char, output line_last, output block_done,
                  output block_sum, input ready);
  modport sink   (input valid, input out_char, input line_last, input block_done,
                  input block_sum, output ready);
endinterface

// ===== hdl/uule_fifo.sv =====
module uule_fifo #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/uule_front.sv =====
module uule_front
  import uule_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 45,
  parameter int unsigned ADDR_W     = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  uule_in_if.sink           in_chan_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output logic [7:0]        push_data_o,
  output logic [ADDR_W-1:0] push_pos_o,
  output uule_tag_t         push_tag_o
);

  localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(LINE_BYTES - 1);

  logic [ADDR_W-1:0] fill_q, fill_d;
  logic              accept;

  assign in_chan_i.ready    = push_ready_i;
  assign push_valid_o       = in_chan_i.valid;
  assign push_data_o        = in_chan_i.data_byte;
  assign push_pos_o         = fill_q;
  assign push_tag_o.blk_end = in_chan_i.block_end;
  assign push_tag_o.close   = (fill_q == LAST_POS) || in_chan_i.block_end;
  assign accept             = in_chan_i.valid && push_ready_i;

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      fill_d = push_tag_o.close ? '0 : fill_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

// ===== hdl/uule_back.sv =====
module uule_back
  import uule_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 45,
  parameter int unsigned ADDR_W     = 6,
  parameter int unsigned CNT_W      = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  logic [7:0]        item_data_i,
  input  logic [ADDR_W-1:0] item_pos_i,
  input  uule_tag_t         item_tag_i,
  uule_out_if.source        out_chan_o
);

  uule_state_e state_q, state_d;

  logic [7:0]       store_q [LINE_BYTES];
  logic [7:0]       rd_data_q;
  logic             rd_ok_q;
  logic [7:0]       a0_q, a1_q, a2_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] base_q, base_d;
  logic             end_q, end_d;
  logic [1:0]       k_q, k_d;
  logic [31:0]      sum_q, sum_d;

  logic             ov_q, ov_d;
  logic [7:0]       oc_q, oc_d;
  logic             ol_q, ol_d;
  logic             od_q, od_d;
  logic [31:0]      os_q, os_d;

  logic             take, ld, rd_en, cap, addr_ok;
  logic [CNT_W:0]   addr_w, next_base_w;

  assign out_chan_o.valid      = ov_q;
  assign out_chan_o.out_char   = oc_q;
  assign out_chan_o.line_last  = ol_q;
  assign out_chan_o.block_done = od_q;
  assign out_chan_o.block_sum  = os_q;

  assign ld          = !ov_q || out_chan_o.ready;
  assign take        = (state_q == ST_TAKE) && item_valid_i;
  assign addr_w      = (CNT_W + 1)'(base_q) + (CNT_W + 1)'(k_q);
  assign addr_ok     = addr_w < {1'b0, count_q};
  assign next_base_w = (CNT_W + 1)'(base_q) + (CNT_W + 1)'(GROUP_BYTES);
  // A group is read as three reads; bytes past the line count come back as zero.
  assign rd_en       = (state_q == ST_FETCH) && (k_q != FETCH_LAST) && addr_ok;
  assign cap         = (state_q == ST_FETCH) && (k_q != 2'd0);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    base_d       = base_q;
    end_d        = end_q;
    k_d          = k_q;
    sum_d        = sum_q;
    item_ready_o = 1'b0;
    ov_d         = ov_q && !out_chan_o.ready;
    oc_d         = oc_q;
    ol_d         = ol_q;
    od_d         = od_q;
    os_d         = os_q;

    case (state_q)
      ST_TAKE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          sum_d = sum_q + {24'd0, item_data_i};
          if (item_tag_i.close) begin
            count_d = CNT_W'(item_pos_i) + CNT_W'(1);
            end_d   = item_tag_i.blk_end;
            base_d  = '0;
            state_d = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (ld) begin
          ov_d    = 1'b1;
          oc_d    = CH_BIAS + 8'(count_q);
          ol_d    = 1'b0;
          od_d    = 1'b0;
          os_d    = '0;
          k_d     = '0;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        k_d = k_q + 2'd1;
        if (k_q == FETCH_LAST) begin
          k_d     = '0;
          state_d = ST_C0;
        end
      end
      ST_C0: begin
        if (ld) begin
          ov_d    = 1'b1;
          oc_d    = bias6(a0_q[7:2]);
          state_d = ST_C1;
        end
      end
      ST_C1: begin
        if (ld) begin
          ov_d    = 1'b1;
          oc_d    = bias6({a0_q[1:0], a1_q[7:4]});
          state_d = ST_C2;
        end
      end
      ST_C2: begin
        if (ld) begin
          ov_d    = 1'b1;
          oc_d    = bias6({a1_q[3:0], a2_q[7:6]});
          state_d = ST_C3;
        end
      end
      ST_C3: begin
        if (ld) begin
          ov_d    = 1'b1;
          oc_d    = bias6(a2_q[5:0]);
          base_d  = next_base_w[CNT_W-1:0];
          state_d = (next_base_w >= {1'b0, count_q}) ? ST_CR : ST_FETCH;
        end
      end
      ST_CR: begin
        if (ld) begin
          ov_d    = 1'b1;
          oc_d    = CH_CR;
          state_d = ST_LF;
        end
      end
      ST_LF: begin
        if (ld) begin
          ov_d    = 1'b1;
          oc_d    = CH_LF;
          ol_d    = 1'b1;
          od_d    = end_q;
          os_d    = end_q ? sum_q : '0;
          if (end_q) begin
            sum_d = '0;
          end
          state_d = ST_TAKE;
        end
      end
      default: begin
        state_d = ST_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_TAKE;
      count_q <= '0;
      base_q  <= '0;
      end_q   <= 1'b0;
      k_q     <= '0;
      sum_q   <= '0;
      ov_q    <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      base_q  <= base_d;
      end_q   <= end_d;
      k_q     <= k_d;
      sum_q   <= sum_d;
      ov_q    <= ov_d;
      rd_ok_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    oc_q <= oc_d;
    ol_q <= ol_d;
    od_q <= od_d;
    os_q <= os_d;
  end

  // Line memory: one write port for incoming bytes, one registered read port.
  always_ff @(posedge clk_i) begin
    if (take) begin
      store_q[item_pos_i] <= item_data_i;
    end
    if (rd_en) begin
      rd_data_q <= store_q[addr_w[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap) begin
      case (k_q)
        2'd1:    a0_q <= rd_ok_q ? rd_data_q : 8'd0;
        2'd2:    a1_q <= rd_ok_q ? rd_data_q : 8'd0;
        default: a2_q <= rd_ok_q ? rd_data_q : 8'd0;
      endcase
    end
  end

endmodule

// ===== hdl/uuencode_line_encoder_with_sum.sv =====
// Encodes a stream of raw bytes into uuencoded lines of up to LINE_BYTES bytes.
// Each line comes out as a length character, four characters for every group
// of three bytes (missing bytes of the last group count as zero), then CR and
// LF; line_last marks the LF, and block_done with the wrapping 32-bit byte sum
// marks the LF of the line closed by the byte flagged block_end. Bytes enter a
// two-entry queue at up to one per cycle and, while no line is being emitted, are
// written into the line memory one per cycle. A closed line is then emitted from
// that memory as the length character, then for each group a fetch of its three
// bytes and its four characters, and then CR and LF; the receiver can hold any
// character off. Input is stalled while a line is being emitted once the queue
// is full.
module uuencode_line_encoder_with_sum
  import uule_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 45
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uule_in_if.sink    in_chan_i,
  uule_out_if.source out_chan_o
);

  localparam int unsigned ADDR_W = $clog2(LINE_BYTES);
  localparam int unsigned CNT_W  = $clog2(LINE_BYTES + 1);
  localparam int unsigned Q_W    = 8 + ADDR_W + $bits(uule_tag_t);

  logic              push_valid, push_ready;
  logic [7:0]        push_data;
  logic [ADDR_W-1:0] push_pos;
  uule_tag_t         push_tag;

  logic              pop_valid, pop_ready;
  logic [Q_W-1:0]    pop_data;
  logic [7:0]        item_data;
  logic [ADDR_W-1:0] item_pos;
  uule_tag_t         item_tag;

  uule_front #(
    .LINE_BYTES (LINE_BYTES),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_chan_i    (in_chan_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data),
    .push_pos_o   (push_pos),
    .push_tag_o   (push_tag)
  );

  uule_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_data, push_pos, push_tag}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign {item_data, item_pos, item_tag} = pop_data;

  uule_back #(
    .LINE_BYTES (LINE_BYTES),
    .ADDR_W     (ADDR_W),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_ready_o (pop_ready),
    .item_data_i  (item_data),
    .item_pos_i   (item_pos),
    .item_tag_i   (item_tag),
    .out_chan_o   (out_chan_o)
  );

endmodule

// ===== hdl/uule_checker.sv =====
`include "assert_macros.svh"

module uule_checker
  import uule_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_char_i,
  input logic        line_last_i,
  input logic        block_done_i,
  input logic [31:0] block_sum_i
);

  // A stalled character must not change under the receiver.
  `ASSERT_CLKD(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i))
  `ASSERT_IMPL(a_last_is_lf, out_valid_i && line_last_i, out_char_i == CH_LF)
  `ASSERT_IMPL(a_done_on_last, out_valid_i && block_done_i, line_last_i)
  `ASSERT_IMPL(a_sum_only_done, out_valid_i && !block_done_i, block_sum_i == 32'd0)

endmodule

bind uuencode_line_encoder_with_sum uule_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_chan_o.valid),
  .out_ready_i  (out_chan_o.ready),
  .out_char_i   (out_chan_o.out_char),
  .line_last_i  (out_chan_o.line_last),
  .block_done_i (out_chan_o.block_done),
  .block_sum_i  (out_chan_o.block_sum)
);
